>>> src/prp_pkg.sv
// Shared types and constants for the page replacement policy block.
// No dependencies; every other file in src depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package prp_pkg;

    localparam int FUNC_W      = 2;
    localparam int PAGE_W      = 6;
    localparam int FRAME_OUT_W = 3;
    localparam int COUNT_W     = 16;
    localparam int POLICY_W    = 2;
    localparam int AGE_W       = 8;

    localparam logic [FUNC_W-1:0] FUNC_ACCESS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FAULT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_FIFO  = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_CLOCK = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_AGING = 2'd2;

    localparam logic [AGE_W-1:0] NEW_AGE = 8'h80;

    // Bit positions of the page table flags; the frame number sits above them.
    localparam int FL_PRESENT = 0;
    localparam int FL_REF     = 1;
    localparam int FL_DIRTY   = 2;
    localparam int FL_W       = 3;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] grant_frame;
        logic [PAGE_W-1:0]      evicted_page;
        logic                   replaced_valid;
        logic                   write_back;
        logic                   miss;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmp_ctl;

endpackage

`default_nettype wire

>>> src/prp_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on prp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface prp_req_if;
    logic                        valid;
    logic                        ready;
    logic [prp_pkg::FUNC_W-1:0]  func;
    logic [prp_pkg::PAGE_W-1:0]  page;
    logic                        is_write;

    modport source (output valid, func, page, is_write, input ready);
    modport sink   (input valid, func, page, is_write, output ready);
endinterface

interface prp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [prp_pkg::FRAME_OUT_W-1:0] grant_frame;
    logic [prp_pkg::PAGE_W-1:0]      evicted_page;
    logic                            replaced_valid;
    logic                            write_back;
    logic                            miss;
    logic [prp_pkg::COUNT_W-1:0]     fault_count;

    modport source (output valid, grant_frame, evicted_page, replaced_valid, write_back,
                    miss, fault_count, input ready);
    modport sink   (input valid, grant_frame, evicted_page, replaced_valid, write_back,
                    miss, fault_count, output ready);
endinterface

`default_nettype wire

>>> src/prp_cmp.sv
// Compare unit for the aging victim search: keeps the best frame seen.
// Depends on prp_pkg (t_cmp_ctl, widths).
`timescale 1ns / 1ps
`default_nettype none

module prp_cmp #(
    parameter int FW = 3
) (
    input  wire logic                       i_clk,
    input  wire prp_pkg::t_cmp_ctl          i_ctl,
    input  wire logic [prp_pkg::AGE_W-1:0]  i_age,
    input  wire logic [prp_pkg::PAGE_W-1:0] i_owner,
    input  wire logic [FW-1:0]              i_frame,
    output logic      [FW-1:0]              o_best_frame
);
    import prp_pkg::*;

    logic [AGE_W-1:0]  r_best_age;
    logic [PAGE_W-1:0] r_best_owner;
    logic [FW-1:0]     r_best_frame;
    logic [AGE_W-1:0]  n_best_age;
    logic [PAGE_W-1:0] n_best_owner;
    logic [FW-1:0]     n_best_frame;
    logic              better;

    // Least age wins; on equal ages the higher page number wins.
    assign better = (i_age < r_best_age) ||
                    ((i_age == r_best_age) && (i_owner > r_best_owner));

    always_comb begin
        n_best_age   = r_best_age;
        n_best_owner = r_best_owner;
        n_best_frame = r_best_frame;
        if (i_ctl.load || (i_ctl.step && better)) begin
            n_best_age   = i_age;
            n_best_owner = i_owner;
            n_best_frame = i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_age   <= n_best_age;
        r_best_owner <= n_best_owner;
        r_best_frame <= n_best_frame;
    end

    assign o_best_frame = r_best_frame;

endmodule

`default_nettype wire

>>> src/page_replacement_policy_top.sv
// Top level of the page replacement policy block: sequencer, page and frame tables.
// Depends on prp_pkg, prp_if (prp_req_if, prp_rsp_if) and prp_cmp.
//
//  Channel   Direction  Handshake      Payload
//  i_req     in         valid / ready  func, page, is_write
//  o_rsp     out        valid / ready  grant_frame, evicted_page, replaced_valid,
//                                      write_back, miss, fault_count
//  i_cfg_*   in         write enable   policy
//
// One item at a time. An access, a resident fault or a tick without aging runs
// S_LOOK, then S_DONE into the output register; a fill adds S_FILL, and a FIFO
// eviction S_VICT_RD, S_VICT_OWN and S_VICT_PT before it. A clock eviction runs
// S_CLK_RD, S_CLK_OWN and S_CLK_CHK per frame visited (at most NUM_FRAMES + 1
// visits, since one pass clears every reference bit), an aging eviction S_AGE_RD
// and S_AGE_CMP per frame, then S_AGE_PICK, and an aging tick S_TICK_RD, S_TICK_OWN
// and, for an occupied frame, S_TICK_CHK per frame. No item is taken while S_CLEAR
// clears the page table after reset; a result waiting on o_rsp stalls S_DONE.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_policy_top #(
    parameter int NUM_PAGES  = 64,
    parameter int NUM_FRAMES = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    prp_req_if.sink                           i_req,
    prp_rsp_if.source                         o_rsp,
    input  wire logic                         i_cfg_we,
    input  wire logic [prp_pkg::POLICY_W-1:0] i_cfg_wdata
);
    import prp_pkg::*;

    localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW    = $clog2(2 * NUM_FRAMES);
    localparam int PTE_W = FW + FL_W;
    localparam int FTE_W = PAGE_W + AGE_W;

    localparam logic [PW-1:0]      LAST_PAGE   = PW'(NUM_PAGES - 1);
    localparam logic [FW-1:0]      LAST_FRAME  = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0]      LAST_VISIT  = CW'(2 * NUM_FRAMES - 1);
    localparam logic [10:0]        PAGE_LIMIT  = 11'(NUM_PAGES);
    localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(NUM_FRAMES);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_VICT_RD,
        S_VICT_OWN,
        S_VICT_PT,
        S_FILL,
        S_CLK_RD,
        S_CLK_OWN,
        S_CLK_CHK,
        S_AGE_RD,
        S_AGE_CMP,
        S_AGE_PICK,
        S_TICK_RD,
        S_TICK_OWN,
        S_TICK_CHK,
        S_DONE
    } t_state;

    function automatic logic [FW-1:0] f_next(input logic [FW-1:0] f);
        return (f == LAST_FRAME) ? '0 : f + FW'(1);
    endfunction

    // Control and datapath registers.
    t_state              r_state,    n_state;
    logic [POLICY_W-1:0] r_policy,   n_policy;
    logic [FW-1:0]       r_fifo_ptr, n_fifo_ptr;
    logic [FW-1:0]       r_hand,     n_hand;
    logic [COUNT_W-1:0]  r_faults,   n_faults;
    logic [PW-1:0]       r_clr,      n_clr;
    logic                r_o_valid,  n_o_valid;
    t_result             r_o_res,    n_o_res;
    logic [COUNT_W-1:0]  r_o_count,  n_o_count;
    logic [FUNC_W-1:0]   r_func,     n_func;
    logic [PAGE_W-1:0]   r_page,     n_page;
    logic                r_wr,       n_wr;
    logic [FW-1:0]       r_frame,    n_frame;
    logic [PAGE_W-1:0]   r_victim,   n_victim;
    logic [AGE_W-1:0]    r_age,      n_age;
    logic [CW-1:0]       r_cnt,      n_cnt;
    logic [FW-1:0]       r_scan,     n_scan;
    t_result             r_res,      n_res;

    // Page table: {frame, dirty, ref, present}. Frame table: {owner, age}.
    logic [PTE_W-1:0] r_pt_mem [NUM_PAGES];
    logic [FTE_W-1:0] r_ft_mem [NUM_FRAMES];
    logic [PTE_W-1:0] r_pt_q;
    logic [FTE_W-1:0] r_ft_q;

    logic             pt_we;
    logic [PW-1:0]    pt_waddr;
    logic [PTE_W-1:0] pt_wdata;
    logic [PW-1:0]    pt_raddr;
    logic             ft_we;
    logic [FW-1:0]    ft_waddr;
    logic [FTE_W-1:0] ft_wdata;
    logic [FW-1:0]    ft_raddr;

    t_cmp_ctl         cmp_ctl;
    logic [FW-1:0]    best_frame;

    logic [PAGE_W-1:0] ft_q_owner;
    logic [AGE_W-1:0]  ft_q_age;
    logic              page_in_range;
    logic              table_full;

    assign ft_q_owner    = r_ft_q[AGE_W +: PAGE_W];
    assign ft_q_age      = r_ft_q[AGE_W-1:0];
    assign page_in_range = 11'(r_page) < PAGE_LIMIT;
    assign table_full    = r_faults >= FRAME_LIMIT;

    prp_cmp #(
        .FW (FW)
    ) u_prp_cmp (
        .i_clk        (i_clk),
        .i_ctl        (cmp_ctl),
        .i_age        (ft_q_age),
        .i_owner      (ft_q_owner),
        .i_frame      (r_scan),
        .o_best_frame (best_frame)
    );

    always_comb begin
        n_state    = r_state;
        n_policy   = i_cfg_we ? i_cfg_wdata : r_policy;
        n_fifo_ptr = r_fifo_ptr;
        n_hand     = r_hand;
        n_faults   = r_faults;
        n_clr      = r_clr;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_res    = r_o_res;
        n_o_count  = r_o_count;
        n_func     = r_func;
        n_page     = r_page;
        n_wr       = r_wr;
        n_frame    = r_frame;
        n_victim   = r_victim;
        n_age      = r_age;
        n_cnt      = r_cnt;
        n_scan     = r_scan;
        n_res      = r_res;

        pt_we    = 1'b0;
        pt_waddr = PW'(r_victim);
        pt_wdata = '0;
        pt_raddr = PW'(r_victim);
        ft_we    = 1'b0;
        ft_waddr = r_scan;
        ft_wdata = '0;
        ft_raddr = r_frame;
        cmp_ctl  = '0;

        unique case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr;
                n_clr    = r_clr + PW'(1);
                if (r_clr == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                pt_raddr = PW'(i_req.page);
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_page  = i_req.page;
                    n_wr    = i_req.is_write;
                    n_res   = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                unique case (r_func)
                    FUNC_ACCESS: begin
                        if (page_in_range && r_pt_q[FL_PRESENT]) begin
                            pt_we            = 1'b1;
                            pt_waddr         = PW'(r_page);
                            pt_wdata         = r_pt_q;
                            pt_wdata[FL_REF] = 1'b1;
                            if (r_wr) begin
                                pt_wdata[FL_DIRTY] = 1'b1;
                            end
                        end else begin
                            n_res.miss = 1'b1;
                        end
                    end
                    FUNC_FAULT: begin
                        if (!page_in_range) begin
                            n_state = S_DONE;
                        end else if (r_pt_q[FL_PRESENT]) begin
                            n_res.grant_frame = FRAME_OUT_W'(r_pt_q[FL_W +: FW]);
                        end else if (!table_full) begin
                            n_frame = FW'(r_faults);
                            n_state = S_FILL;
                        end else begin
                            unique case (r_policy)
                                POLICY_CLOCK: begin
                                    n_cnt   = '0;
                                    n_state = S_CLK_RD;
                                end
                                POLICY_AGING: begin
                                    n_scan  = '0;
                                    n_state = S_AGE_RD;
                                end
                                default: begin
                                    // FIFO, and the unused code behaves the same.
                                    n_frame    = r_fifo_ptr;
                                    n_fifo_ptr = f_next(r_fifo_ptr);
                                    n_state    = S_VICT_RD;
                                end
                            endcase
                        end
                    end
                    FUNC_TICK: begin
                        if (r_policy == POLICY_AGING) begin
                            n_scan  = '0;
                            n_state = S_TICK_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_VICT_RD: begin
                ft_raddr = r_frame;
                n_state  = S_VICT_OWN;
            end
            S_VICT_OWN: begin
                n_victim = ft_q_owner;
                pt_raddr = PW'(ft_q_owner);
                n_state  = S_VICT_PT;
            end
            S_VICT_PT: begin
                n_res.evicted_page   = r_victim;
                n_res.replaced_valid = 1'b1;
                n_res.write_back     = r_pt_q[FL_DIRTY];
                pt_we                = 1'b1;
                pt_waddr             = PW'(r_victim);
                pt_wdata             = '0;
                n_state              = S_FILL;
            end
            S_FILL: begin
                ft_we                = 1'b1;
                ft_waddr             = r_frame;
                ft_wdata             = {r_page, NEW_AGE};
                pt_we                = 1'b1;
                pt_waddr             = PW'(r_page);
                pt_wdata             = '0;
                pt_wdata[FL_W +: FW] = r_frame;
                pt_wdata[FL_PRESENT] = 1'b1;
                n_res.grant_frame    = FRAME_OUT_W'(r_frame);
                if (r_faults != '1) begin
                    n_faults = r_faults + COUNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_CLK_RD: begin
                ft_raddr = r_hand;
                n_state  = S_CLK_OWN;
            end
            S_CLK_OWN: begin
                n_victim = ft_q_owner;
                pt_raddr = PW'(ft_q_owner);
                n_state  = S_CLK_CHK;
            end
            S_CLK_CHK: begin
                n_hand = f_next(r_hand);
                if (r_pt_q[FL_REF]) begin
                    // Second chance: drop the reference bit and move on.
                    pt_we            = 1'b1;
                    pt_waddr         = PW'(r_victim);
                    pt_wdata         = r_pt_q;
                    pt_wdata[FL_REF] = 1'b0;
                    n_cnt            = r_cnt + CW'(1);
                    if (r_cnt == LAST_VISIT) begin
                        n_frame = f_next(r_hand);
                        n_state = S_VICT_RD;
                    end else begin
                        n_state = S_CLK_RD;
                    end
                end else begin
                    // The read address stays on the victim, so its entry is reread.
                    n_frame = r_hand;
                    n_state = S_VICT_PT;
                end
            end
            S_AGE_RD: begin
                ft_raddr = r_scan;
                n_state  = S_AGE_CMP;
            end
            S_AGE_CMP: begin
                cmp_ctl.load = (r_scan == '0);
                cmp_ctl.step = 1'b1;
                if (r_scan == LAST_FRAME) begin
                    n_state = S_AGE_PICK;
                end else begin
                    n_scan  = r_scan + FW'(1);
                    n_state = S_AGE_RD;
                end
            end
            S_AGE_PICK: begin
                n_frame = best_frame;
                n_state = S_VICT_RD;
            end
            S_TICK_RD: begin
                ft_raddr = r_scan;
                n_state  = S_TICK_OWN;
            end
            S_TICK_OWN: begin
                n_victim = ft_q_owner;
                n_age    = ft_q_age >> 1;
                pt_raddr = PW'(ft_q_owner);
                if (COUNT_W'(r_scan) < r_faults) begin
                    n_state = S_TICK_CHK;
                end else begin
                    // A free frame only shifts; its owner field means nothing.
                    ft_we    = 1'b1;
                    ft_waddr = r_scan;
                    ft_wdata = {ft_q_owner, ft_q_age >> 1};
                    if (r_scan == LAST_FRAME) begin
                        n_state = S_DONE;
                    end else begin
                        n_scan  = r_scan + FW'(1);
                        n_state = S_TICK_RD;
                    end
                end
            end
            S_TICK_CHK: begin
                ft_we    = 1'b1;
                ft_waddr = r_scan;
                ft_wdata = {r_victim, r_age};
                if (r_pt_q[FL_REF]) begin
                    ft_wdata[AGE_W-1] = 1'b1;
                    pt_we             = 1'b1;
                    pt_waddr          = PW'(r_victim);
                    pt_wdata          = r_pt_q;
                    pt_wdata[FL_REF]  = 1'b0;
                end
                if (r_scan == LAST_FRAME) begin
                    n_state = S_DONE;
                end else begin
                    n_scan  = r_scan + FW'(1);
                    n_state = S_TICK_RD;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_res   = r_res;
                    n_o_count = r_faults;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_policy   <= POLICY_FIFO;
            r_fifo_ptr <= '0;
            r_hand     <= '0;
            r_faults   <= '0;
            r_clr      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_policy   <= n_policy;
            r_fifo_ptr <= n_fifo_ptr;
            r_hand     <= n_hand;
            r_faults   <= n_faults;
            r_clr      <= n_clr;
            r_o_valid  <= n_o_valid;
        end
        r_o_res  <= n_o_res;
        r_o_count <= n_o_count;
        r_func   <= n_func;
        r_page   <= n_page;
        r_wr     <= n_wr;
        r_frame  <= n_frame;
        r_victim <= n_victim;
        r_age    <= n_age;
        r_cnt    <= n_cnt;
        r_scan   <= n_scan;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
        r_pt_q <= r_pt_mem[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            r_ft_mem[ft_waddr] <= ft_wdata;
        end
        r_ft_q <= r_ft_mem[ft_raddr];
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.grant_frame    = r_o_res.grant_frame;
    assign o_rsp.evicted_page   = r_o_res.evicted_page;
    assign o_rsp.replaced_valid = r_o_res.replaced_valid;
    assign o_rsp.write_back     = r_o_res.write_back;
    assign o_rsp.miss           = r_o_res.miss;
    assign o_rsp.fault_count    = r_o_count;

endmodule

`default_nettype wire

>>> src/prp_checker.sv
// Port-level checks for page_replacement_policy_top, attached with bind.
// Depends on prp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module prp_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_req_valid,
    input wire logic                            i_req_ready,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic [prp_pkg::FRAME_OUT_W-1:0] i_grant_frame,
    input wire logic                            i_replaced_valid,
    input wire logic                            i_write_back,
    input wire logic                            i_miss,
    input wire logic [prp_pkg::COUNT_W-1:0]     i_fault_count
);
    import prp_pkg::*;

    // The block works on one item at a time, so it is busy right after a transfer.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while the previous item is still at work");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_write_back) |-> i_replaced_valid)
        else $error("writeback reported without an evicted page");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_miss) |-> (!i_replaced_valid && (i_grant_frame == '0)))
        else $error("access miss carries fault fields");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_fault_count) && $stable(i_grant_frame)))
        else $error("stalled result changed");

endmodule

bind page_replacement_policy_top prp_checker u_prp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_grant_frame    (o_rsp.grant_frame),
    .i_replaced_valid (o_rsp.replaced_valid),
    .i_write_back     (o_rsp.write_back),
    .i_miss           (o_rsp.miss),
    .i_fault_count    (o_rsp.fault_count)
);

`default_nettype wire

>>> tb/sv/page_replacement_policy_top_tb.sv
// Self-checking testbench for page_replacement_policy_top: a directed table, random phases
// under every replacement policy, and a closing stretch of back-to-back FIFO evictions.
// Depends on prp_pkg, prp_if (prp_req_if, prp_rsp_if) and the RTL of the block.
`timescale 1ns / 1ps

module page_replacement_policy_top_tb;
    import prp_pkg::*;

    localparam int NUM_PAGES    = 64;
    localparam int NUM_FRAMES   = 8;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 115;

    localparam logic [FUNC_W-1:0]   FUNC_SPARE   = 2'd3;
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

    typedef struct packed {
        t_result            res;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [FUNC_W-1:0]   func;
        logic [PAGE_W-1:0]   page;
        logic                is_write;
        logic                fixed;
        t_outcome            want;
    } t_row;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [POLICY_W-1:0] cfg_wdata;

    prp_req_if req_if ();
    prp_rsp_if rsp_if ();

    page_replacement_policy_top #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mirror of the page and frame tables.
    logic [FRAME_OUT_W-1:0] pg_frame [NUM_PAGES];
    logic [FL_W-1:0]        pg_flags [NUM_PAGES];
    logic [PAGE_W-1:0]      fr_owner [NUM_FRAMES];
    logic [AGE_W-1:0]       fr_age   [NUM_FRAMES];
    logic [FRAME_OUT_W-1:0] fifo_ptr;
    logic [FRAME_OUT_W-1:0] hand;
    logic [COUNT_W-1:0]     faults_taken;
    logic [POLICY_W-1:0]    policy_now;

    t_outcome outcomes_due [$];
    int       mismatches = 0;
    bit       idle_on = 1'b1;
    bit       hold_off_request = 1'b0;

    string field_names [6] = '{"grant_frame", "evicted_page", "replaced_valid",
                               "write_back", "miss", "fault_count"};

    function automatic logic [FRAME_OUT_W-1:0] after_frame(input logic [FRAME_OUT_W-1:0] f);
        return (f == NUM_FRAMES - 1) ? '0 : f + 1'b1;
    endfunction

    // Referenced owners get a second chance; the hand ends one past the victim.
    function automatic logic [FRAME_OUT_W-1:0] clock_victim();
        logic [FRAME_OUT_W-1:0] f;
        logic [PAGE_W-1:0]      p;
        for (int n = 0; n < 2 * NUM_FRAMES; n++) begin
            f = hand;
            p = fr_owner[f];
            hand = after_frame(f);
            if (pg_flags[p][FL_REF]) begin
                pg_flags[p][FL_REF] = 1'b0;
            end else begin
                return f;
            end
        end
        return hand;
    endfunction

    function automatic logic [FRAME_OUT_W-1:0] aging_victim();
        logic [FRAME_OUT_W-1:0] best;
        best = '0;
        for (int f = 1; f < NUM_FRAMES; f++) begin
            if (fr_age[f] < fr_age[best] ||
                (fr_age[f] == fr_age[best] && fr_owner[f] > fr_owner[best])) begin
                best = FRAME_OUT_W'(f);
            end
        end
        return best;
    endfunction

    function automatic void shift_ages();
        for (int f = 0; f < NUM_FRAMES; f++) begin
            fr_age[f] = fr_age[f] >> 1;
            // Free frames only shift; their owner entry is stale.
            if (f < faults_taken && pg_flags[fr_owner[f]][FL_REF]) begin
                fr_age[f] = fr_age[f] | NEW_AGE;
                pg_flags[fr_owner[f]][FL_REF] = 1'b0;
            end
        end
    endfunction

    function automatic t_outcome replace_outcome(input logic [FUNC_W-1:0] func,
                                                 input logic [PAGE_W-1:0] page,
                                                 input logic wr);
        t_outcome               o;
        logic [FRAME_OUT_W-1:0] f;
        logic [PAGE_W-1:0]      v;
        o = '0;
        case (func)
            FUNC_ACCESS: begin
                if (pg_flags[page][FL_PRESENT]) begin
                    pg_flags[page][FL_REF] = 1'b1;
                    if (wr) pg_flags[page][FL_DIRTY] = 1'b1;
                end else begin
                    o.res.miss = 1'b1;
                end
            end
            FUNC_FAULT: begin
                if (pg_flags[page][FL_PRESENT]) begin
                    o.res.grant_frame = pg_frame[page];
                end else begin
                    if (faults_taken < NUM_FRAMES) begin
                        f = faults_taken[FRAME_OUT_W-1:0];
                    end else begin
                        if (policy_now == POLICY_CLOCK) begin
                            f = clock_victim();
                        end else if (policy_now == POLICY_AGING) begin
                            f = aging_victim();
                        end else begin
                            f = fifo_ptr;
                            fifo_ptr = after_frame(f);
                        end
                        v = fr_owner[f];
                        o.res.evicted_page   = v;
                        o.res.replaced_valid = 1'b1;
                        o.res.write_back     = pg_flags[v][FL_DIRTY];
                        pg_flags[v] = '0;
                        pg_frame[v] = '0;
                    end
                    fr_owner[f] = page;
                    fr_age[f]   = NEW_AGE;
                    pg_frame[page] = f;
                    pg_flags[page] = '0;
                    pg_flags[page][FL_PRESENT] = 1'b1;
                    o.res.grant_frame = f;
                    if (faults_taken != '1) faults_taken = faults_taken + 1'b1;
                end
            end
            FUNC_TICK: begin
                if (policy_now == POLICY_AGING) shift_ages();
            end
            default: ;
        endcase
        o.count = faults_taken;
        return o;
    endfunction

    task automatic compare_outcome(input t_outcome want, input t_outcome got);
        logic [COUNT_W-1:0] w [6];
        logic [COUNT_W-1:0] g [6];
        w = '{COUNT_W'(want.res.grant_frame), COUNT_W'(want.res.evicted_page),
              COUNT_W'(want.res.replaced_valid), COUNT_W'(want.res.write_back),
              COUNT_W'(want.res.miss), want.count};
        g = '{COUNT_W'(got.res.grant_frame), COUNT_W'(got.res.evicted_page),
              COUNT_W'(got.res.replaced_valid), COUNT_W'(got.res.write_back),
              COUNT_W'(got.res.miss), got.count};
        for (int i = 0; i < 6; i++) begin
            if (g[i] !== w[i]) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", field_names[i], w[i], g[i]);
            end
        end
    endtask

    // Offers one request; valid is left high after the transfer so that a following
    // request keeps it asserted without a gap.
    task automatic offer_request(input logic [FUNC_W-1:0] func, input logic [PAGE_W-1:0] page,
                                 input logic wr, input logic fixed, input t_outcome want);
        t_outcome predicted;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= func;
        req_if.page     <= page;
        req_if.is_write <= wr;
        do @(posedge clk); while (!req_if.ready);
        predicted = replace_outcome(func, page, wr);
        outcomes_due.push_back(fixed ? want : predicted);
    endtask

    // The policy only changes once every outstanding result has come back.
    task automatic write_policy(input logic [POLICY_W-1:0] value);
        req_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        policy_now = value;
    endtask

    function automatic t_row dir_row(input logic [POLICY_W-1:0] pol,
                                     input logic [FUNC_W-1:0] func,
                                     input logic [PAGE_W-1:0] page, input logic wr,
                                     input logic fixed, input logic [FRAME_OUT_W-1:0] alloc,
                                     input logic [PAGE_W-1:0] repl, input logic rv,
                                     input logic wb, input logic miss,
                                     input logic [COUNT_W-1:0] cnt);
        t_row r;
        r.policy   = pol;
        r.func     = func;
        r.page     = page;
        r.is_write = wr;
        r.fixed    = fixed;
        r.want.res.grant_frame    = alloc;
        r.want.res.evicted_page   = repl;
        r.want.res.replaced_valid = rv;
        r.want.res.write_back     = wb;
        r.want.res.miss           = miss;
        r.want.count              = cnt;
        return r;
    endfunction

    initial begin : stimulus
        t_row                directed [$];
        logic [POLICY_W-1:0] phase_policy [8];
        logic [PAGE_W-1:0]   base;
        logic [PAGE_W-1:0]   page;
        logic [FUNC_W-1:0]   func;
        int                  pick;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= POLICY_FIFO;
        req_if.valid    <= 1'b0;
        req_if.func     <= FUNC_ACCESS;
        req_if.page     <= '0;
        req_if.is_write <= 1'b0;
        foreach (pg_frame[i]) begin
            pg_frame[i] = '0;
            pg_flags[i] = '0;
        end
        foreach (fr_owner[i]) begin
            fr_owner[i] = '0;
            fr_age[i]   = '0;
        end
        fifo_ptr     = '0;
        hand         = '0;
        faults_taken = '0;
        policy_now   = POLICY_FIFO;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(dir_row(POLICY_FIFO, FUNC_ACCESS, 6'd0, 1'b0, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b1, 16'd0));
        directed.push_back(dir_row(POLICY_FIFO, FUNC_FAULT, 6'd63, 1'b0, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 16'd1));
        // A fault on a resident page reports its frame and does not count.
        directed.push_back(dir_row(POLICY_FIFO, FUNC_FAULT, 6'd63, 1'b1, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 16'd1));
        directed.push_back(dir_row(POLICY_FIFO, FUNC_ACCESS, 6'd63, 1'b1, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 16'd1));
        directed.push_back(dir_row(POLICY_FIFO, FUNC_TICK, 6'd21, 1'b0, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 16'd1));
        directed.push_back(dir_row(POLICY_FIFO, FUNC_SPARE, 6'd42, 1'b1, 1'b1,
                                   3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 16'd1));
        for (int p = 1; p < NUM_FRAMES; p++)
            directed.push_back(dir_row(POLICY_FIFO, FUNC_FAULT, PAGE_W'(p), 1'b0, 1'b0,
                                       '0, '0, 1'b0, 1'b0, 1'b0, '0));
        // All frames are full: the oldest frame holds the dirty page 63.
        directed.push_back(dir_row(POLICY_FIFO, FUNC_FAULT, 6'd62, 1'b0, 1'b1,
                                   3'd0, 6'd63, 1'b1, 1'b1, 1'b0, 16'd9));
        directed.push_back(dir_row(POLICY_CLOCK, FUNC_ACCESS, 6'd62, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_CLOCK, FUNC_ACCESS, 6'd1, 1'b1, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_CLOCK, FUNC_FAULT, 6'd40, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_AGING, FUNC_TICK, 6'd0, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_AGING, FUNC_ACCESS, 6'd3, 1'b1, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_AGING, FUNC_TICK, 6'd0, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_AGING, FUNC_FAULT, 6'd41, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        // The unused policy code replaces like FIFO and ignores ticks.
        directed.push_back(dir_row(POLICY_SPARE, FUNC_FAULT, 6'd42, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_SPARE, FUNC_TICK, 6'd0, 1'b0, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));
        directed.push_back(dir_row(POLICY_SPARE, FUNC_ACCESS, 6'd0, 1'b1, 1'b0,
                                   '0, '0, 1'b0, 1'b0, 1'b0, '0));

        foreach (directed[i]) begin
            if (directed[i].policy != policy_now) write_policy(directed[i].policy);
            offer_request(directed[i].func, directed[i].page, directed[i].is_write,
                          directed[i].fixed, directed[i].want);
        end

        // Each phase works on a small set of pages so that hits and evictions both occur.
        phase_policy = '{POLICY_CLOCK, POLICY_AGING, POLICY_FIFO, POLICY_AGING,
                         POLICY_SPARE, POLICY_CLOCK, POLICY_AGING, POLICY_FIFO};
        for (int ph = 0; ph < 8; ph++) begin
            write_policy(phase_policy[ph]);
            base = PAGE_W'($urandom_range(0, NUM_PAGES - 12));
            if (ph == 1) hold_off_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) func = FUNC_ACCESS;
                else if (pick < 80) func = FUNC_FAULT;
                else if (pick < 95) func = FUNC_TICK;
                else func = FUNC_SPARE;
                if ($urandom_range(0, 99) < 85) page = base + PAGE_W'($urandom_range(0, 11));
                else page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
                offer_request(func, page, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        // The last stretch runs without gaps; cycling sixteen pages through eight FIFO
        // frames evicts on nearly every fault.
        idle_on = 1'b0;
        write_policy(POLICY_FIFO);
        for (int n = 0; n < 48; n++)
            offer_request(FUNC_FAULT, PAGE_W'(n % 16), 1'(n % 2), 1'b0, '0);
        for (int n = 0; n < 24; n++)
            offer_request((n % 3 == 0) ? FUNC_ACCESS : FUNC_FAULT,
                          PAGE_W'($urandom_range(0, NUM_PAGES - 1)),
                          1'($urandom_range(0, 1)), 1'b0, '0);

        req_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : result_side
        int       stall_left;
        t_outcome got;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got.res.grant_frame    = rsp_if.grant_frame;
                got.res.evicted_page   = rsp_if.evicted_page;
                got.res.replaced_valid = rsp_if.replaced_valid;
                got.res.write_back     = rsp_if.write_back;
                got.res.miss           = rsp_if.miss;
                got.count              = rsp_if.fault_count;
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    $error("result transfer with nothing pending, fault_count %0d",
                           got.count);
                end else begin
                    compare_outcome(outcomes_due.pop_front(), got);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_off_request) begin
                // Long hold-off so that the block backs up and stops taking requests.
                hold_off_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
